// ----- hw/rtl/pdc_pkg.sv -----
// Package for the PPPoE discovery client: request/result payload types,
// phase encoding, client context and discovery codes.
// No dependencies.
package pdc_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic [7:0] CODE_PADI = 8'h09;
    localparam logic [7:0] CODE_PADO = 8'h07;
    localparam logic [7:0] CODE_PADR = 8'h19;
    localparam logic [7:0] CODE_PADS = 8'h65;
    localparam logic [7:0] CODE_PADT = 8'ha7;

    localparam logic [3:0]  HDR_VER_TYPE  = 4'h1;
    localparam logic [10:0] UNIQUE_LENGTH = 11'd8;
    localparam logic [47:0] MAC_BROADCAST = 48'hffff_ffff_ffff;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_RUNNING = 2'd1;
    localparam logic [1:0] EV_STOPPED = 2'd2;

    localparam logic [2:0] PH_NUM_IDLE = 3'd0;
    localparam logic [2:0] PH_NUM_DISC = 3'd1;
    localparam logic [2:0] PH_NUM_REQ  = 3'd2;
    localparam logic [2:0] PH_NUM_RUN  = 3'd3;
    localparam logic [2:0] PH_NUM_STOP = 3'd4;

    localparam logic [1:0]  REG_RETRY_TIMEOUT = 2'd0;
    localparam logic [1:0]  REG_MAX_RESENDS   = 2'd1;
    localparam logic [19:0] RETRY_TIMEOUT_RST = 20'd500;
    localparam logic [7:0]  MAX_RESENDS_RST   = 8'd16;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_DISC = 5'b00010,
        PH_REQ  = 5'b00100,
        PH_RUN  = 5'b01000,
        PH_STOP = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  frame_version;
        logic [3:0]  frame_kind;
        logic [7:0]  frame_code;
        logic [15:0] frame_session;
        logic [47:0] source_mac;
        logic [63:0] rx_unique_tag;
        logic [10:0] rx_unique_length;
        logic        rx_has_cookie;
        logic [63:0] nonce;
    } t_req;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_code;
        logic [47:0] dest_mac;
        logic [15:0] send_session;
        logic        include_cookie;
        logic        include_unique;
        logic [63:0] unique_out;
        logic [1:0]  event_code;
        logic [2:0]  phase_out;
    } t_rsp;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  resend_left;
        logic        timer_armed;
        logic [63:0] unique_value;
        logic [47:0] peer_address;
        logic [15:0] session_value;
        logic        cookie_seen;
    } t_ctx;

endpackage

// ----- hw/rtl/pdc_step.sv -----
// Single-step logic of the discovery client: next context, retry timer and
// result for one request. Combinational.
// Depends on pdc_pkg.
module pdc_step #(
    parameter int TIMER_BITS = 20
) (
    input  pdc_pkg::t_req          i_req,
    input  pdc_pkg::t_ctx          i_ctx,
    input  logic [TIMER_BITS-1:0]  i_timer,
    input  logic [19:0]            i_cfg_timeout,
    input  logic [7:0]             i_cfg_resends,
    output pdc_pkg::t_ctx          o_ctx,
    output logic [TIMER_BITS-1:0]  o_timer,
    output pdc_pkg::t_rsp          o_rsp
);

    localparam int CW = (TIMER_BITS > 20) ? TIMER_BITS : 20;
    localparam logic [CW-1:0] TIMER_MAX = CW'({TIMER_BITS{1'b1}});

    logic [CW-1:0]         timeout_ext;
    logic [TIMER_BITS-1:0] timer_load;
    logic                  hdr_ok;
    logic                  uniq_ok;
    logic                  mac_ok;
    logic                  fire;

    assign timeout_ext = CW'(i_cfg_timeout);
    assign timer_load  = (timeout_ext > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX)
                                                   : TIMER_BITS'(timeout_ext);
    assign hdr_ok  = (i_req.frame_version == pdc_pkg::HDR_VER_TYPE) &&
                     (i_req.frame_kind == pdc_pkg::HDR_VER_TYPE);
    assign uniq_ok = (i_req.rx_unique_length == pdc_pkg::UNIQUE_LENGTH) &&
                     (i_req.rx_unique_tag == i_ctx.unique_value);
    assign mac_ok  = (i_req.source_mac == i_ctx.peer_address);
    assign fire    = (i_timer <= TIMER_BITS'(1));

    always_comb begin
        pdc_pkg::t_ctx n_ctx;
        pdc_pkg::t_rsp n_rsp;
        logic [TIMER_BITS-1:0] n_timer;
        logic do_padi;
        logic do_padr;

        n_ctx   = i_ctx;
        n_timer = i_timer;
        n_rsp   = '0;
        do_padi = 1'b0;
        do_padr = 1'b0;

        case (i_req.opcode)
            pdc_pkg::OP_START: begin
                if (i_ctx.phase == pdc_pkg::PH_IDLE) begin
                    n_ctx.resend_left = i_cfg_resends;
                    n_ctx.cookie_seen = 1'b0;
                    n_ctx.phase       = pdc_pkg::PH_DISC;
                    do_padi           = 1'b1;
                end
            end
            pdc_pkg::OP_TICK: begin
                if (i_ctx.timer_armed) begin
                    if (fire) begin
                        n_ctx.timer_armed = 1'b0;
                        if (i_ctx.phase == pdc_pkg::PH_DISC) begin
                            do_padi = 1'b1;
                        end else if (i_ctx.phase == pdc_pkg::PH_REQ) begin
                            if (i_ctx.resend_left == 8'd0) begin
                                do_padi           = 1'b1;
                                n_ctx.resend_left = i_cfg_resends;
                                n_ctx.phase       = pdc_pkg::PH_DISC;
                            end else begin
                                do_padr = 1'b1;
                            end
                        end
                    end else begin
                        n_timer = i_timer - TIMER_BITS'(1);
                    end
                end
            end
            pdc_pkg::OP_FRAME: begin
                if (i_ctx.phase != pdc_pkg::PH_IDLE && hdr_ok) begin
                    n_ctx.cookie_seen = i_req.rx_has_cookie;
                    case (i_ctx.phase)
                        pdc_pkg::PH_DISC: begin
                            if (i_req.frame_code == pdc_pkg::CODE_PADO && uniq_ok) begin
                                n_ctx.peer_address = i_req.source_mac;
                                n_ctx.phase        = pdc_pkg::PH_REQ;
                                do_padr            = 1'b1;
                            end
                        end
                        pdc_pkg::PH_REQ: begin
                            if (i_req.frame_code == pdc_pkg::CODE_PADS && uniq_ok &&
                                mac_ok && i_req.frame_session != 16'd0) begin
                                n_ctx.session_value = i_req.frame_session;
                                n_ctx.phase         = pdc_pkg::PH_RUN;
                                n_ctx.timer_armed   = 1'b0;
                                n_rsp.event_code    = pdc_pkg::EV_RUNNING;
                            end
                        end
                        pdc_pkg::PH_RUN: begin
                            if (i_req.frame_code == pdc_pkg::CODE_PADT && mac_ok &&
                                i_req.frame_session == i_ctx.session_value) begin
                                n_ctx.phase      = pdc_pkg::PH_STOP;
                                n_rsp.event_code = pdc_pkg::EV_STOPPED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                if (i_ctx.phase == pdc_pkg::PH_RUN) begin
                    n_rsp.send_valid   = 1'b1;
                    n_rsp.send_code    = pdc_pkg::CODE_PADT;
                    n_rsp.dest_mac     = i_ctx.peer_address;
                    n_rsp.send_session = i_ctx.session_value;
                end
                n_ctx.timer_armed = 1'b0;
                n_timer           = '0;
                n_ctx.phase       = pdc_pkg::PH_IDLE;
            end
        endcase

        // PADI / PADR send; cookie and peer already reflect this request
        if (do_padi || do_padr) begin
            n_ctx.unique_value   = i_req.nonce;
            n_rsp.send_valid     = 1'b1;
            n_rsp.include_unique = 1'b1;
            n_rsp.unique_out     = i_req.nonce;
            n_ctx.timer_armed    = 1'b1;
            n_timer              = timer_load;
            if (do_padi) begin
                n_rsp.send_code = pdc_pkg::CODE_PADI;
                n_rsp.dest_mac  = pdc_pkg::MAC_BROADCAST;
            end else begin
                n_rsp.send_code      = pdc_pkg::CODE_PADR;
                n_rsp.dest_mac       = n_ctx.peer_address;
                n_rsp.include_cookie = n_ctx.cookie_seen;
                if (n_ctx.resend_left != 8'd0) begin
                    n_ctx.resend_left = n_ctx.resend_left - 8'd1;
                end
            end
        end

        case (n_ctx.phase)
            pdc_pkg::PH_DISC: n_rsp.phase_out = pdc_pkg::PH_NUM_DISC;
            pdc_pkg::PH_REQ:  n_rsp.phase_out = pdc_pkg::PH_NUM_REQ;
            pdc_pkg::PH_RUN:  n_rsp.phase_out = pdc_pkg::PH_NUM_RUN;
            pdc_pkg::PH_STOP: n_rsp.phase_out = pdc_pkg::PH_NUM_STOP;
            default:          n_rsp.phase_out = pdc_pkg::PH_NUM_IDLE;
        endcase

        o_ctx   = n_ctx;
        o_timer = n_timer;
        o_rsp   = n_rsp;
    end

endmodule

// ----- hw/rtl/pppoe_discovery_client.sv -----
// PPPoE discovery client top level: request and result registers, client
// context, retry timer and APB configuration registers.
// Depends on pdc_pkg and pdc_step.

// Takes one request per clock cycle (start, timer tick, received discovery
// header, stop) and returns exactly one result for each. A request passes
// through the request register and then the result register; the step logic
// between them reads and updates the client context, so requests stream back
// to back; the request side only stalls while a result is held because the
// result side is not ready. The user must write the configuration registers
// (retry timeout at 0x0, PADR resend limit at 0x4) over APB only while no
// request is outstanding; the block itself does not enforce this.
module pppoe_discovery_client #(
    parameter int TIMER_BITS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  pdc_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output pdc_pkg::t_rsp  o_rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic                  r_req_valid;
    pdc_pkg::t_req         r_req;
    logic                  r_rsp_valid;
    pdc_pkg::t_rsp         r_rsp;
    pdc_pkg::t_ctx         r_ctx;
    logic [TIMER_BITS-1:0] r_timer;
    logic [19:0]           r_cfg_timeout;
    logic [7:0]            r_cfg_resends;

    pdc_pkg::t_ctx         n_ctx;
    logic [TIMER_BITS-1:0] n_timer;
    pdc_pkg::t_rsp         n_rsp;
    logic                  advance;
    logic                  cfg_wr;

    assign advance     = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || advance;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    always_comb begin
        case ({1'b0, paddr[2]})
            pdc_pkg::REG_RETRY_TIMEOUT: prdata = 32'(r_cfg_timeout);
            pdc_pkg::REG_MAX_RESENDS:   prdata = 32'(r_cfg_resends);
            default:                    prdata = '0;
        endcase
    end

    pdc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_req         (r_req),
        .i_ctx         (r_ctx),
        .i_timer       (r_timer),
        .i_cfg_timeout (r_cfg_timeout),
        .i_cfg_resends (r_cfg_resends),
        .o_ctx         (n_ctx),
        .o_timer       (n_timer),
        .o_rsp         (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout <= pdc_pkg::RETRY_TIMEOUT_RST;
            r_cfg_resends <= pdc_pkg::MAX_RESENDS_RST;
        end else if (cfg_wr) begin
            case ({1'b0, paddr[2]})
                pdc_pkg::REG_RETRY_TIMEOUT: r_cfg_timeout <= pwdata[19:0];
                pdc_pkg::REG_MAX_RESENDS:   r_cfg_resends <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_ctx       <= '{phase:         pdc_pkg::PH_IDLE,
                             resend_left:   pdc_pkg::MAX_RESENDS_RST,
                             timer_armed:   1'b0,
                             unique_value:  64'd0,
                             peer_address:  48'd0,
                             session_value: 16'd0,
                             cookie_seen:   1'b0};
            r_timer     <= '0;
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (advance) begin
                r_rsp_valid <= 1'b1;
                r_ctx       <= n_ctx;
                r_timer     <= n_timer;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
